>>> src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold on a rising clk edge.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/abap_pkg.sv
// Shared types and constants of the block-average apogee detector.
package abap_pkg;

    localparam int ALT_W    = 24;
    localparam int TIME_W   = 32;
    localparam int APOGEE_W = 23;

    localparam logic signed [ALT_W-1:0] ALT_MAX = 24'sh7FFFFF;
    localparam logic signed [ALT_W-1:0] ALT_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [ALT_W-1:0] alt;
        logic [TIME_W-1:0]       stamp;
    } hist_entry_t;

endpackage

>>> src/abap_history.sv
// History ring buffer: one synchronous memory, push port and indexed read port.
module abap_history #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  abap_pkg::hist_entry_t push_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_idx,
    output abap_pkg::hist_entry_t rd_data
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    abap_pkg::hist_entry_t mem [DEPTH];

    logic [IDX_W-1:0]      wr_ptr_reg;
    logic [IDX_W-1:0]      wr_ptr_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    abap_pkg::hist_entry_t rd_data_reg;
    logic                  empty_slot_reg;
    logic signed [IDX_W:0] addr_diff;
    logic [IDX_W-1:0]      rd_addr;

    // Logical index 0 is the youngest entry, just below the write pointer.
    always_comb
    begin
        addr_diff = $signed({1'b0, wr_ptr_reg}) - $signed({1'b0, rd_idx})
                    - $signed((IDX_W+1)'(1));
        if (addr_diff[IDX_W])
        begin
            addr_diff = addr_diff + $signed((IDX_W+1)'(DEPTH));
        end
        rd_addr = addr_diff[IDX_W-1:0];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            if (wr_ptr_reg == IDX_W'(DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + IDX_W'(1);
            end
            if (fill_reg != FILL_W'(DEPTH))
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg    <= mem[rd_addr];
            empty_slot_reg <= ({1'b0, rd_idx} >= (IDX_W+1)'(fill_reg));
        end
    end

    // Slots never written read as zero.
    assign rd_data = empty_slot_reg ? '0 : rd_data_reg;

endmodule

>>> src/altitude_block_average_apogee.sv
// Top level of the block-average barometric apogee detector.
//
// Input channel: sample_altitude (signed cm) and sample_time (ms), taken on
// a rising clk edge with sample_valid high and sample_stall low.
// Output channel: one result transaction per input transaction, held on the
// result ports while result_valid is high and result_stall is high.
// Each sample goes through: accept, block average (only on the sample that
// closes a block: multiply by the reciprocal of SAMPLES_PER_BLOCK), history
// walk (one read of the history memory per cycle), result load. A new sample
// is taken once the previous one is loaded.
// The next sample is accepted while a result still waits in the output
// register; a stalled receiver holds the block in result load.
// Reset clears counters, sums, reference, filtered value and the history
// fill count; history slots not yet written read as zero.
`include "assert_macros.svh"

module altitude_block_average_apogee #(
    parameter int SAMPLES_PER_BLOCK = 8,
    parameter int HISTORY_DEPTH     = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic signed [23:0]  sample_altitude,
    input  logic [31:0]         sample_time,
    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [23:0]  filtered_altitude,
    output logic [31:0]         filtered_time,
    output logic                block_done,
    output logic                calibrating,
    output logic                past_apogee,
    output logic [22:0]         apogee_altitude,
    output logic [31:0]         apogee_time
);

    localparam int ALT_W   = abap_pkg::ALT_W;
    localparam int TIME_W  = abap_pkg::TIME_W;
    localparam int APO_W   = abap_pkg::APOGEE_W;
    localparam int LOG_N   = $clog2(SAMPLES_PER_BLOCK);
    localparam int CNT_W   = (SAMPLES_PER_BLOCK > 1) ? LOG_N : 1;
    localparam int SUM_W   = ALT_W + LOG_N;
    localparam int MAG_W   = SUM_W;
    localparam int K       = MAG_W + LOG_N;
    localparam int PROD_W  = 2 * MAG_W + 1;
    localparam int AVG_W   = ALT_W + 1;
    localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [63:0] MAGIC_FULL =
        ((64'd1 << K) + 64'(SAMPLES_PER_BLOCK) - 64'd1) / 64'(SAMPLES_PER_BLOCK);
    localparam logic [MAG_W:0] MAGIC = MAGIC_FULL[MAG_W:0];

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_DIV2 = 3'd2;
    localparam logic [2:0] S_DIV3 = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_LAST = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]              state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    ref_valid_reg;
    logic signed [ALT_W-1:0] ref_reg;
    logic signed [ALT_W-1:0] cur_alt_reg;
    logic [TIME_W-1:0]       cur_time_reg;
    logic [TIME_W-1:0]       t_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    chk_vld_reg;
    logic                    past_reg;
    logic                    stop_reg;
    logic [APO_W-1:0]        best_alt_reg;
    logic [TIME_W-1:0]       best_time_reg;

    logic                    result_valid_reg;
    logic signed [ALT_W-1:0] out_alt_reg;
    logic [TIME_W-1:0]       out_time_reg;
    logic                    out_done_reg;
    logic                    out_cal_reg;
    logic                    out_past_reg;
    logic [APO_W-1:0]        out_apo_alt_reg;
    logic [TIME_W-1:0]       out_apo_time_reg;

    logic                    accept;
    logic                    out_load;
    logic [CNT_W:0]          count_inc;
    logic                    block_end;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W:0]   neg_sum;
    logic [AVG_W-1:0]        q_mag;
    logic signed [AVG_W-1:0] avg;
    logic signed [AVG_W:0]   diff;
    logic signed [ALT_W-1:0] diff_sat;
    logic                    push;
    logic                    rd_en;
    abap_pkg::hist_entry_t   push_data;
    abap_pkg::hist_entry_t   rd_data;
    logic                    apogee_nonzero;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);
    assign out_load     = (state_reg == S_OUT) && (!result_valid_reg || !result_stall);

    assign count_inc = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign block_end = (count_inc == (CNT_W+1)'(SAMPLES_PER_BLOCK));
    assign sum_next  = sum_reg + SUM_W'(sample_altitude);
    assign neg_sum   = -((SUM_W+1)'(sum_reg)) + (SUM_W+1)'(SAMPLES_PER_BLOCK - 1);

    // floor(sum / N) via |sum| (biased for negatives) times ceil(2^K / N)
    assign q_mag = prod_reg[K +: AVG_W];
    assign avg   = neg_reg ? -$signed(q_mag) : $signed(q_mag);
    assign diff  = (AVG_W+1)'(avg) - (AVG_W+1)'(ref_reg);

    always_comb
    begin
        if (diff > (AVG_W+1)'(abap_pkg::ALT_MAX))
        begin
            diff_sat = abap_pkg::ALT_MAX;
        end
        else if (diff < (AVG_W+1)'(abap_pkg::ALT_MIN))
        begin
            diff_sat = abap_pkg::ALT_MIN;
        end
        else
        begin
            diff_sat = diff[ALT_W-1:0];
        end
    end

    assign push            = (state_reg == S_DIV3) && ref_valid_reg;
    assign push_data.alt   = cur_alt_reg;
    assign push_data.stamp = cur_time_reg;
    assign rd_en           = (state_reg == S_SCAN);

    abap_history #(
        .DEPTH (HISTORY_DEPTH),
        .IDX_W (IDX_W)
    ) u_history (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .rd_en     (rd_en),
        .rd_idx    (idx_reg),
        .rd_data   (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            ref_valid_reg <= 1'b0;
            ref_reg       <= '0;
            cur_alt_reg   <= '0;
            cur_time_reg  <= '0;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= (state_reg == S_SCAN);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sum_reg <= sum_next;
                        idx_reg <= '0;
                        if (block_end)
                        begin
                            count_reg <= '0;
                            state_reg <= S_DIV1;
                        end
                        else
                        begin
                            count_reg <= count_inc[CNT_W-1:0];
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_DIV1:
                begin
                    sum_reg   <= '0;
                    state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    state_reg <= S_DIV3;
                end
                S_DIV3:
                begin
                    if (!ref_valid_reg)
                    begin
                        ref_reg       <= avg[ALT_W-1:0];
                        ref_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        cur_alt_reg  <= diff_sat;
                        cur_time_reg <= t_reg;
                    end
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (idx_reg == IDX_W'(HISTORY_DEPTH - 1))
                    begin
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_LAST:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg         <= sample_time;
            done_reg      <= block_end;
            past_reg      <= 1'b1;
            stop_reg      <= 1'b0;
            best_alt_reg  <= '0;
            best_time_reg <= '0;
        end
        if (state_reg == S_DIV1)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            mag_reg <= sum_reg[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_reg[MAG_W-1:0];
        end
        if (state_reg == S_DIV2)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(MAGIC);
        end
        // youngest entry first; the first entry at or below the filtered value ends the walk
        if (chk_vld_reg && !stop_reg)
        begin
            if (cur_alt_reg >= rd_data.alt)
            begin
                past_reg <= 1'b0;
                stop_reg <= 1'b1;
            end
            else if (rd_data.alt > $signed({1'b0, best_alt_reg}))
            begin
                best_alt_reg  <= rd_data.alt[APO_W-1:0];
                best_time_reg <= rd_data.stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_alt_reg      <= cur_alt_reg;
            out_time_reg     <= cur_time_reg;
            out_done_reg     <= done_reg;
            out_cal_reg      <= !ref_valid_reg;
            out_past_reg     <= past_reg;
            out_apo_alt_reg  <= past_reg ? best_alt_reg : '0;
            out_apo_time_reg <= past_reg ? best_time_reg : '0;
        end
    end

    assign result_valid      = result_valid_reg;
    assign filtered_altitude = out_alt_reg;
    assign filtered_time     = out_time_reg;
    assign block_done        = out_done_reg;
    assign calibrating       = out_cal_reg;
    assign past_apogee       = out_past_reg;
    assign apogee_altitude   = out_apo_alt_reg;
    assign apogee_time       = out_apo_time_reg;

    assign apogee_nonzero = (apogee_altitude != '0) || (apogee_time != '0);

    `ASSERT_NEVER(a_push_during_walk, push && rd_en, "history push collides with walk read")
    `ASSERT_NEVER(a_ref_lost, $fell(ref_valid_reg), "reference cleared outside reset")
    `ASSERT_CLK(a_load_from_out, $rose(result_valid) |-> $past(state_reg) == S_OUT, "stray result")
    `ASSERT_NEVER(a_apogee_zero, result_valid && !past_apogee && apogee_nonzero, "stray apogee")

endmodule
